@@ sv/spe_pkg.sv @@
`default_nettype none
package spe_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;
   localparam int WEIGHT_BITS_DEF  = 16;

   localparam int VIDX_BITS   = 6;
   localparam int VCOUNT_BITS = 7;
   localparam int DIST_BITS   = 22;
   localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3FFFFF;
   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd64;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BAD_VERT = 2'd2;

   localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ADD2  = 7'b0000010,
      S_SEL   = 7'b0000100,
      S_E_RD  = 7'b0001000,
      S_E_CHK = 7'b0010000,
      S_E_CMP = 7'b0100000,
      S_O_RD  = 7'b1000000
   } ctl_state_type;

   typedef struct packed {
      logic add_first;
      logic add_second;
      logic clear;
      logic run_start;
      logic run_bad;
      logic sel_start;
      logic sel_scan;
      logic sel_pick;
      logic edge_rd;
      logic edge_chk;
      logic edge_cmp;
      logic out_start;
      logic out_rd;
      logic out_ld;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic add_ok;
      logic src_bad;
      logic sel_done;
      logic best_valid;
      logic edge_end;
      logic edge_match;
      logic out_last;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ sv/shortest_path_engine_unit.sv @@
// Shortest path engine: undirected graph, non-negative weights, Dijkstra.
// Request channel (req_*): op 0 adds an edge (two table entries) and answers
// with one status beat; op 2 clears the table with no answer; op 1 runs from
// req_source_vertex and answers with one beat per vertex in index order,
// rsp_last on the final one. A bad source gives one status beat.
// Add: the status beat is registered in the next cycle; a good add then writes its second entry in S_ADD2.
// Run: each settle round scans the vertex_count distances (one memory read
// a cycle) and then walks every table entry through S_E_RD and S_E_CHK,
// adding S_E_CMP when the entry leaves the picked vertex for a vertex below
// vcount; each result beat is read from the distance memory and then loaded in S_O_RD.
// One item is in work at a time; req_stall is high while busy or while a
// result beat waits in the output register under rsp_stall.
// Reset empties the edge table and sets vertex_count to 64; the memories are not
// cleared. A held rsp_stall freezes the result beat and the engine behind it.
// Write vertex_count over the csr_ port while the engine is idle; the block does not enforce it.
`default_nettype none
module shortest_path_engine_unit
   import spe_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_op,
   input  wire logic [VIDX_BITS-1:0]  req_from_vertex,
   input  wire logic [VIDX_BITS-1:0]  req_to_vertex,
   input  wire logic [15:0]           req_edge_weight,
   input  wire logic [VIDX_BITS-1:0]  req_source_vertex,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [VIDX_BITS-1:0]       rsp_vertex_index,
   output logic [DIST_BITS-1:0]       rsp_distance,
   output logic                       rsp_reachable,
   output logic                       rsp_last,
   output logic [1:0]                 rsp_status,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [1:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [VCOUNT_BITS-1:0] vertex_count_ff;
   logic [VCOUNT_BITS-1:0] vcount;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_pready = 1'b1;
   assign csr_prdata = {25'd0, vertex_count_ff};

   always_ff @(posedge clock) begin
      if (reset)
         vertex_count_ff <= VCOUNT_RESET;
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr == {REG_VERTEX_COUNT, 1'b0})
         vertex_count_ff <= csr_pwdata[VCOUNT_BITS-1:0];
   end

   // clamp to 1..MAX_VERTICES
   always_comb begin
      if (vertex_count_ff == '0)
         vcount = VCOUNT_BITS'(1);
      else if (vertex_count_ff > VCOUNT_BITS'(MAX_VERTICES))
         vcount = VCOUNT_BITS'(MAX_VERTICES);
      else
         vcount = vertex_count_ff;
   end

   spe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   spe_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .vcount            (vcount),
      .req_from_vertex   (req_from_vertex),
      .req_to_vertex     (req_to_vertex),
      .req_edge_weight   (req_edge_weight),
      .req_source_vertex (req_source_vertex),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vertex_index  (rsp_vertex_index),
      .rsp_distance      (rsp_distance),
      .rsp_reachable     (rsp_reachable),
      .rsp_last          (rsp_last),
      .rsp_status        (rsp_status)
   );

endmodule
`default_nettype wire

@@ sv/spe_ctrl.sv @@
`default_nettype none
module spe_ctrl
   import spe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [1:0]  req_op,
   output logic             req_stall,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   ctl_state_type state_ff, state_in;
   logic o_ld_ff, o_ld_in;   // output-load phase of the result walk

   always_comb begin
      state_in = state_ff;
      o_ld_in  = o_ld_ff;
      cmd      = '0;
      req_stall = !(state_ff == S_IDLE && stat.out_free);
      case (state_ff)
         S_IDLE: begin
            if (req_valid && stat.out_free) begin
               case (req_op)
                  OP_ADD: begin
                     cmd.add_first = 1'b1;
                     if (stat.add_ok) state_in = S_ADD2;
                  end
                  OP_RUN: begin
                     if (stat.src_bad) begin
                        cmd.run_bad = 1'b1;
                     end else begin
                        cmd.run_start = 1'b1;
                        cmd.sel_start = 1'b1;
                        state_in = S_SEL;
                     end
                  end
                  OP_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         S_ADD2: begin
            cmd.add_second = 1'b1;
            state_in = S_IDLE;
         end
         S_SEL: begin
            cmd.sel_scan = 1'b1;
            if (stat.sel_done) begin
               if (stat.best_valid) begin
                  cmd.sel_pick = 1'b1;
                  state_in = S_E_RD;
               end else begin
                  cmd.out_start = 1'b1;
                  o_ld_in = 1'b0;
                  state_in = S_O_RD;
               end
            end
         end
         S_E_RD: begin
            if (stat.edge_end) begin
               cmd.sel_start = 1'b1;
               state_in = S_SEL;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in = S_E_CHK;
            end
         end
         S_E_CHK: begin
            if (stat.edge_match) begin
               cmd.edge_chk = 1'b1;
               state_in = S_E_CMP;
            end else begin
               state_in = S_E_RD;
            end
         end
         S_E_CMP: begin
            cmd.edge_cmp = 1'b1;
            state_in = S_E_RD;
         end
         S_O_RD: begin
            if (!o_ld_ff) begin
               cmd.out_rd = 1'b1;
               o_ld_in = 1'b1;
            end else if (stat.out_free) begin
               cmd.out_ld = 1'b1;
               o_ld_in = 1'b0;
               if (stat.out_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         o_ld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         o_ld_ff  <= o_ld_in;
      end
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == S_IDLE))
      else $error("beat accepted while busy");
   a_add_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD2) |=> (state_ff == S_IDLE))
      else $error("second edge write did not finish");
   a_pick_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.sel_pick |-> (state_ff == S_SEL && stat.sel_done))
      else $error("pick outside finished scan");

endmodule
`default_nettype wire

@@ sv/spe_dpath.sv @@
`default_nettype none
module spe_dpath
   import spe_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   output dp_stat_type                 stat,
   input  wire logic [VCOUNT_BITS-1:0] vcount,
   input  wire logic [VIDX_BITS-1:0]   req_from_vertex,
   input  wire logic [VIDX_BITS-1:0]   req_to_vertex,
   input  wire logic [15:0]            req_edge_weight,
   input  wire logic [VIDX_BITS-1:0]   req_source_vertex,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [VIDX_BITS-1:0]        rsp_vertex_index,
   output logic [DIST_BITS-1:0]        rsp_distance,
   output logic                        rsp_reachable,
   output logic                        rsp_last,
   output logic [1:0]                  rsp_status
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int DW  = WEIGHT_BITS + 7;
   localparam int XW  = (DW > DIST_BITS) ? DW : DIST_BITS;
   localparam int EEW = 2 * VW + WEIGHT_BITS;

   logic [EEW-1:0] edge_mem [MAX_EDGES];
   logic [DW-1:0]  dist_mem [MAX_VERTICES];

   logic [EEW-1:0]   edge_rd_ff;
   logic [DW-1:0]    dist_rd_ff;
   logic [EW:0]      edge_cnt_ff, e_ff;
   logic [MAX_VERTICES-1:0] known_ff, done_ff;
   logic [CW-1:0]    idx_ff;
   logic             rd_v_ff;
   logic [VW-1:0]    rd_i_ff;
   logic             best_v_ff;
   logic [VW-1:0]    best_i_ff, u_ff;
   logic [DW-1:0]    best_d_ff, du_ff;
   logic [VW-1:0]    pa_ff, pb_ff;
   logic [WEIGHT_BITS-1:0] pw_ff;

   logic                   out_free;
   logic [WEIGHT_BITS-1:0] w_in;
   logic                   a_bad, full;
   logic [VW-1:0]          e_src, e_dst;
   logic [WEIGHT_BITS-1:0] e_wt;
   logic [DW-1:0]          cand;
   logic                   improve;
   logic [VW-1:0]          idx_v;
   logic [XW-1:0]          dx;
   logic                   scan_issue;

   assign out_free = !rsp_valid || !rsp_stall;
   assign w_in  = WEIGHT_BITS'(req_edge_weight);
   assign a_bad = ({1'b0, req_from_vertex} >= vcount) || ({1'b0, req_to_vertex} >= vcount);
   assign full  = edge_cnt_ff > (EW+1)'(MAX_EDGES - 2);
   assign {e_src, e_dst, e_wt} = edge_rd_ff;
   assign cand    = du_ff + DW'(e_wt);
   assign improve = !known_ff[e_dst] || (cand < dist_rd_ff);
   assign idx_v   = idx_ff[VW-1:0];
   assign dx      = XW'(dist_rd_ff);
   assign scan_issue = cmd.sel_scan && (VCOUNT_BITS'(idx_ff) < vcount);

   always_comb begin
      stat.out_free   = out_free;
      stat.add_ok     = !a_bad && !full;
      stat.src_bad    = {1'b0, req_source_vertex} >= vcount;
      stat.sel_done   = (VCOUNT_BITS'(idx_ff) == vcount) && !rd_v_ff;
      stat.best_valid = best_v_ff;
      stat.edge_end   = (e_ff == edge_cnt_ff);
      stat.edge_match = (e_src == u_ff) && (VCOUNT_BITS'(e_dst) < vcount);
      stat.out_last   = (VCOUNT_BITS'(idx_ff) + 1'b1 == vcount);
   end

   // edge table: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.add_first && !a_bad && !full)
         edge_mem[edge_cnt_ff[EW-1:0]] <= {req_from_vertex[VW-1:0],
                                          req_to_vertex[VW-1:0], w_in};
      else if (cmd.add_second)
         edge_mem[edge_cnt_ff[EW-1:0]] <= {pb_ff, pa_ff, pw_ff};
      if (cmd.edge_rd)
         edge_rd_ff <= edge_mem[e_ff[EW-1:0]];
   end

   // distance store: one write port, one registered read
   always_ff @(posedge clock) begin
      if (cmd.run_start)
         dist_mem[req_source_vertex[VW-1:0]] <= '0;
      else if (cmd.edge_cmp && improve)
         dist_mem[e_dst] <= cand;
      if (scan_issue || cmd.out_rd)
         dist_rd_ff <= dist_mem[idx_v];
      else if (cmd.edge_chk)
         dist_rd_ff <= dist_mem[e_dst];
   end

   always_ff @(posedge clock) begin
      pa_ff <= req_from_vertex[VW-1:0];
      pb_ff <= req_to_vertex[VW-1:0];
      pw_ff <= w_in;
      rd_i_ff <= idx_v;
      if (cmd.sel_pick) begin
         u_ff  <= best_i_ff;
         du_ff <= best_d_ff;
      end
      if (rd_v_ff && known_ff[rd_i_ff] && !done_ff[rd_i_ff] &&
          (!best_v_ff || dist_rd_ff < best_d_ff)) begin
         best_i_ff <= rd_i_ff;
         best_d_ff <= dist_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_cnt_ff <= '0;
         e_ff        <= '0;
         known_ff    <= '0;
         done_ff     <= '0;
         idx_ff      <= '0;
         rd_v_ff     <= 1'b0;
         best_v_ff   <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         rd_v_ff <= scan_issue;
         if (cmd.clear) edge_cnt_ff <= '0;
         else if ((cmd.add_first && !a_bad && !full) || cmd.add_second)
            edge_cnt_ff <= edge_cnt_ff + 1'b1;
         if (cmd.run_start) begin
            known_ff <= MAX_VERTICES'(1) << req_source_vertex[VW-1:0];
            done_ff  <= '0;
         end
         if (cmd.sel_start) begin
            idx_ff    <= '0;
            best_v_ff <= 1'b0;
         end else if (scan_issue || cmd.out_ld) begin
            idx_ff <= idx_ff + 1'b1;
         end else if (cmd.out_start) begin
            idx_ff <= '0;
         end
         if (rd_v_ff && known_ff[rd_i_ff] && !done_ff[rd_i_ff])
            best_v_ff <= 1'b1;
         if (cmd.sel_pick) begin
            done_ff[best_i_ff] <= 1'b1;
            e_ff <= '0;
         end else if (cmd.edge_rd) begin
            e_ff <= e_ff + 1'b1;
         end
         if (cmd.edge_cmp && improve) known_ff[e_dst] <= 1'b1;
         if (cmd.add_first || cmd.run_bad || cmd.out_ld) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_first || cmd.run_bad) begin
         rsp_vertex_index <= '0;
         rsp_distance     <= '0;
         rsp_reachable    <= 1'b0;
         rsp_last         <= 1'b1;
         if (cmd.run_bad || a_bad) rsp_status <= ST_BAD_VERT;
         else if (full)            rsp_status <= ST_FULL;
         else                      rsp_status <= ST_OK;
      end else if (cmd.out_ld) begin
         rsp_vertex_index <= VIDX_BITS'(idx_ff);
         rsp_reachable    <= known_ff[idx_v];
         rsp_last         <= stat.out_last;
         rsp_status       <= ST_OK;
         if (!known_ff[idx_v])          rsp_distance <= '0;
         else if (dx > XW'(DIST_MAX))   rsp_distance <= DIST_MAX;
         else                           rsp_distance <= dx[DIST_BITS-1:0];
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      edge_cnt_ff <= (EW+1)'(MAX_EDGES))
      else $error("edge count past table size");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.add_first || cmd.run_bad || cmd.out_ld) |-> out_free)
      else $error("result register overwritten");
   a_pick_known: assert property (@(posedge clock) disable iff (reset)
      cmd.sel_pick |=> (known_ff[u_ff] && done_ff[u_ff]))
      else $error("picked vertex not settled");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
   import spe_pkg::*;

   localparam logic [1:0] OP_NONE     = 2'd3;
   localparam int         EDGE_SLOTS  = 256;
   localparam int         VERT_SLOTS  = 64;
   localparam int         CYCLE_LIMIT = 4000000;
   localparam int         SETTLE      = 64;

   typedef struct {
      logic [VIDX_BITS-1:0] vidx;
      logic [DIST_BITS-1:0] dist_val;
      logic                 reach;
      logic                 last;
      logic [1:0]           status;
   } beat_type;

   typedef struct {
      int         setvc;
      logic [1:0] op;
      int         f;
      int         t;
      int         w;
      int         s;
      int         exp_st;
   } row_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   logic [1:0]            req_op = OP_NONE;
   logic [VIDX_BITS-1:0]  req_from_vertex = 0;
   logic [VIDX_BITS-1:0]  req_to_vertex = 0;
   logic [15:0]           req_edge_weight = 0;
   logic [VIDX_BITS-1:0]  req_source_vertex = 0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   logic [VIDX_BITS-1:0]  rsp_vertex_index;
   logic [DIST_BITS-1:0]  rsp_distance;
   logic                  rsp_reachable;
   logic                  rsp_last;
   logic [1:0]            rsp_status;
   logic                  csr_psel = 0;
   logic                  csr_penable = 0;
   logic                  csr_pwrite = 0;
   logic [1:0]            csr_paddr = 0;
   logic [31:0]           csr_pwdata = 0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   shortest_path_engine_unit uut (.*);

   // graph copy kept by the testbench
   int    edge_src [EDGE_SLOTS];
   int    edge_dst [EDGE_SLOTS];
   int    edge_wt  [EDGE_SLOTS];
   int    edge_count = 0;
   int    vcount_reg = 64;
   beat_type pending_beats[$];
   int    errors = 0;
   int    cycles = 0;
   bit    burst = 0;
   int    stall_left = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int eff_vertices(input int vc);
      if (vc < 1) return 1;
      if (vc > VERT_SLOTS) return VERT_SLOTS;
      return vc;
   endfunction

   function automatic beat_type status_beat(input logic [1:0] st);
      beat_type b;
      b.vidx = 0; b.dist_val = 0; b.reach = 0; b.last = 1; b.status = st;
      return b;
   endfunction

   // Dijkstra over the stored table; distances do not depend on tie order
   task automatic predict_paths(input logic [1:0] op, input int f, input int t,
                                input int w, input int s, input bit push);
      int     n;
      int     u;
      longint dist_v[VERT_SLOTS];
      bit     known[VERT_SLOTS];
      bit     done[VERT_SLOTS];
      longint cand;
      beat_type b;
      n = eff_vertices(vcount_reg);
      case (op)
         OP_ADD: begin
            if (f >= n || t >= n) begin
               if (push) pending_beats.push_back(status_beat(ST_BAD_VERT));
            end else if (edge_count + 2 > EDGE_SLOTS) begin
               if (push) pending_beats.push_back(status_beat(ST_FULL));
            end else begin
               edge_src[edge_count] = f; edge_dst[edge_count] = t; edge_wt[edge_count] = w;
               edge_src[edge_count+1] = t; edge_dst[edge_count+1] = f;
               edge_wt[edge_count+1] = w;
               edge_count += 2;
               if (push) pending_beats.push_back(status_beat(ST_OK));
            end
         end
         OP_CLEAR: edge_count = 0;
         OP_RUN: begin
            if (s >= n) begin
               if (push) pending_beats.push_back(status_beat(ST_BAD_VERT));
            end else begin
               for (int i = 0; i < VERT_SLOTS; i++) begin
                  dist_v[i] = 0; known[i] = 0; done[i] = 0;
               end
               known[s] = 1;
               for (int k = 0; k < n; k++) begin
                  u = -1;
                  for (int i = 0; i < n; i++)
                     if (known[i] && !done[i] && (u < 0 || dist_v[i] < dist_v[u])) u = i;
                  if (u < 0) break;
                  done[u] = 1;
                  for (int e = 0; e < edge_count; e++) begin
                     if (edge_src[e] == u && edge_dst[e] < n) begin
                        cand = dist_v[u] + edge_wt[e];
                        if (!known[edge_dst[e]] || cand < dist_v[edge_dst[e]]) begin
                           known[edge_dst[e]] = 1;
                           dist_v[edge_dst[e]] = cand;
                        end
                     end
                  end
               end
               if (push)
                  for (int i = 0; i < n; i++) begin
                     b.vidx = VIDX_BITS'(i);
                     b.dist_val = DIST_BITS'((dist_v[i] > DIST_MAX) ? DIST_MAX : dist_v[i]);
                     b.reach = known[i];
                     b.last = (i == n - 1);
                     b.status = ST_OK;
                     pending_beats.push_back(b);
                  end
            end
         end
         default: ;
      endcase
   endtask

   // result side: check each beat and draw a stall per beat
   always @(posedge clock) begin : rsp_side
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            report("unexpected beat, vertex", rsp_vertex_index, 0);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_vertex_index !== want.vidx) report("vertex_index", rsp_vertex_index, want.vidx);
            if (rsp_distance !== want.dist_val) report("distance", rsp_distance, want.dist_val);
            if (rsp_reachable !== want.reach) report("reachable", rsp_reachable, want.reach);
            if (rsp_last !== want.last) report("last", rsp_last, want.last);
            if (rsp_status !== want.status) report("status", rsp_status, want.status);
         end
         stall_left = burst ? 0 : $urandom_range(0, 19);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send(input logic [1:0] op, input int f, input int t, input int w,
                       input int s, input int exp_st);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_from_vertex <= VIDX_BITS'(f);
      req_to_vertex <= VIDX_BITS'(t);
      req_edge_weight <= 16'(w);
      req_source_vertex <= VIDX_BITS'(s);
      do @(posedge clock); while (req_stall);
      if (exp_st < 0) begin
         predict_paths(op, f, t, w, s, 1);
      end else begin
         predict_paths(op, f, t, w, s, 0);
         pending_beats.push_back(status_beat(2'(exp_st)));
      end
   endtask

   // clear and op-3 items give no beat, so allow time for them to finish
   task automatic drain();
      req_valid <= 0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic set_vertex_count(input int value);
      drain();
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 2'(4 * REG_VERTEX_COUNT); csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      vcount_reg = value & 32'h7F;
      csr_pwrite <= 0; csr_penable <= 0;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[6:0] !== vcount_reg[6:0]) report("vertex_count readback",
                                                      csr_prdata[6:0], vcount_reg);
      csr_psel <= 0; csr_penable <= 0;
      @(posedge clock);
   endtask

   function automatic int pick_weight();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
   endfunction

   // mostly legal adds and runs on a small graph, some noise
   task automatic random_phase(input int vc, input int count);
      int n;
      int r;
      if (vc >= 0) set_vertex_count(vc);
      n = eff_vertices(vcount_reg);
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 55)
            send(OP_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight(),
                 $urandom_range(0, 63), -1);
         else if (r < 85)
            send(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535),
                 $urandom_range(0, n - 1), -1);
         else if (r < 89)
            send(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 65535), $urandom_range(0, 63), -1);
         else if (r < 93)
            send(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 65535), $urandom_range(0, 63), -1);
         else
            send(2'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 63),
                 pick_weight(), $urandom_range(0, 63), -1);
      end
   endtask

   row_type dir_rows[] = '{
      '{-1, OP_RUN,   0,  0,     0, 63, -1},
      '{-1, OP_ADD,  63,  0, 65535,  0, ST_OK},
      '{-1, OP_ADD,   0,  0,     0,  0, ST_OK},
      '{-1, OP_ADD,   1,  2,     0,  0, ST_OK},
      '{-1, OP_ADD,   2, 63, 43690,  0, ST_OK},
      '{-1, OP_ADD,   0,  1, 21845,  0, ST_OK},
      '{-1, OP_RUN,   0,  0,     0,  0, -1},
      '{-1, OP_NONE, 63, 63, 65535, 63, -1},
      '{-1, OP_RUN,   0,  0,     0, 42, -1},
      '{-1, OP_CLEAR, 0,  0,     0,  0, -1},
      '{-1, OP_RUN,   0,  0,     0,  0, -1},
      '{ 4, OP_ADD,   4,  0,     7,  0, ST_BAD_VERT},
      '{-1, OP_ADD,   0, 63,     7,  0, ST_BAD_VERT},
      '{-1, OP_ADD,   0,  3,     9,  0, ST_OK},
      '{-1, OP_RUN,   0,  0,     0,  4, ST_BAD_VERT},
      '{64, OP_ADD,  10,  1,     5,  0, ST_OK},
      '{-1, OP_ADD,   1,  3,     2,  0, ST_OK},
      '{ 4, OP_RUN,   0,  0,     0,  1, -1},
      '{ 0, OP_RUN,   0,  0,     0,  0, -1},
      '{-1, OP_RUN,   0,  0,     0,  1, ST_BAD_VERT},
      '{-1, OP_ADD,   0,  0,     3,  0, ST_OK},
      '{-1, OP_ADD,   0,  1,     3,  0, ST_BAD_VERT},
      '{127, OP_RUN,  0,  0,     0, 63, -1},
      '{-1, OP_CLEAR, 0,  0,     0,  0, -1}
   };

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].setvc >= 0) set_vertex_count(dir_rows[i].setvc);
         send(dir_rows[i].op, dir_rows[i].f, dir_rows[i].t, dir_rows[i].w,
              dir_rows[i].s, dir_rows[i].exp_st);
      end

      random_phase(6, 20);
      random_phase(3, 20);
      burst = 1;
      random_phase(10, 20);
      burst = 0;
      random_phase(2, 15);
      random_phase(12, 10);
      drain();
      random_phase(-1, 10);

      // fill the table past full on a small graph
      set_vertex_count(8);
      send(OP_CLEAR, 0, 0, 0, 0, -1);
      for (int k = 0; k < 131; k++)
         send(OP_ADD, $urandom_range(0, 7), $urandom_range(0, 7), pick_weight(), 0, -1);
      send(OP_RUN, 0, 0, 0, $urandom_range(0, 7), -1);

      // one wide graph at full size
      set_vertex_count(64);
      send(OP_CLEAR, 0, 0, 0, 0, -1);
      for (int k = 0; k < 20; k++)
         send(OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63), pick_weight(), 0, -1);
      send(OP_RUN, 0, 0, 0, $urandom_range(0, 63), -1);
      send(OP_RUN, 0, 0, 0, $urandom_range(0, 63), -1);

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/spe_pkg.sv
sv/spe_ctrl.sv
sv/spe_dpath.sv
sv/shortest_path_engine_unit.sv
tb/tb_top.sv
